[hdl/rcpd_pkg.sv]
// shared constants and types of the rc pwm channel decoder
package rcpd_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 12;
  localparam int unsigned TIME_BITS_DEF     = 32;

  localparam int unsigned CHANNELS   = 4;
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned TIMEOUT_W  = 32;
  localparam int unsigned DEFAULT_W  = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [PULSE_W-1:0]   PULSE_MIN_RST = 16'd1000;
  localparam logic [PULSE_W-1:0]   PULSE_MAX_RST = 16'd2000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 32'd100000;
  localparam logic [DEFAULT_W-1:0] THR_DEF_RST   = 13'd0;
  localparam logic [DEFAULT_W-1:0] AXIS_DEF_RST  = 13'd2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE_MIN   = 3'd0,
    REG_PULSE_MAX   = 3'd1,
    REG_TIMEOUT     = 3'd2,
    REG_THR_DEFAULT = 3'd3,
    REG_YAW_DEFAULT = 3'd4,
    REG_PIT_DEFAULT = 3'd5,
    REG_ROL_DEFAULT = 3'd6
  } cfg_reg_e;

  // operands and start strobe handed to the divider
  typedef struct packed {
    logic               start;
    logic [PULSE_W-1:0] dividend;
    logic [PULSE_W-1:0] divisor;
  } div_req_t;

endpackage

[hdl/rcpd_div.sv]
// restoring divider, one quotient bit per cycle, for the width normalization
module rcpd_div
  import rcpd_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  div_req_t                 req_i,
  output logic                     done_o,
  output logic [FRACTION_BITS-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(FRACTION_BITS);

  logic                     busy_q;
  logic                     done_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [PULSE_W-1:0]       rem_q;
  logic [PULSE_W-1:0]       rem_d;
  logic [PULSE_W-1:0]       divisor_q;
  logic [FRACTION_BITS-1:0] quot_q;
  logic [PULSE_W:0]         shifted;
  logic                     bit_d;

  // remainder stays below the divisor, so the shifted value fits one extra bit
  always_comb begin
    shifted = {rem_q, 1'b0};
    bit_d   = (shifted >= {1'b0, divisor_q});
    if (bit_d) begin
      rem_d = PULSE_W'(shifted - {1'b0, divisor_q});
    end else begin
      rem_d = shifted[PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FRACTION_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= req_i.dividend;
      divisor_q <= req_i.divisor;
      quot_q    <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[FRACTION_BITS-2:0], bit_d};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[hdl/rc_pwm_channel_decoder.sv]
// top level of the rc pwm channel decoder
//
// Each input transaction on s_axis is one timer tick carrying the four receiver pin
// levels (bit0 throttle, bit1 yaw, bit2 pitch, bit3 roll). The block follows one
// channel at a time: a rising edge on that pin records the start tick, the falling
// edge ends the pulse, the width is normalized to 0..1.0 (1 << FRACTION_BITS) and
// the block moves on to the next channel. Every tick gives one output transaction
// on m_axis with all four channel values; tuser carries the lost flag, raised when
// no pulse has ended within lost_timeout ticks, and then the failsafe defaults
// are shown instead.
// A tick with no pulse end goes from idle to the final step, an ending pulse adds the
// normalize step and an unclamped width the shared one-bit-per-cycle divider step.
// s_axis_tready_o is high only while the sequencer is idle; one finished result can
// wait in the output register while the next tick is accepted, and a stalled
// m_axis holds the block in its final step until the register frees up.
// Reset loads the register defaults, clears the channel values, the tick counter
// and the edge tracking; the first tick after reset counts a high pin as a rise.
// The user must write cfg_* registers only while idle; the block does not enforce it.
module rc_pwm_channel_decoder
  import rcpd_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int unsigned TIME_BITS     = TIME_BITS_DEF,
  localparam int unsigned VAL_W        = FRACTION_BITS + 1,
  localparam int unsigned OUT_W        = ((CHANNELS * VAL_W + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,   // pin_levels[3:0], zero pad
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_W-1:0]      m_axis_tdata_o,   // throttle_out, yaw_out, pitch_out,
                                                  // roll_out, zero pad
  output logic                  m_axis_tuser_o    // signal_lost
);

  localparam logic [VAL_W-1:0]     ValueOne = VAL_W'(1) << FRACTION_BITS;
  localparam logic [CFG_DATA_W-1:0] OneWide = CFG_DATA_W'(1) << FRACTION_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e state_q;

  logic [PULSE_W-1:0]   pulse_min_q;
  logic [PULSE_W-1:0]   pulse_max_q;
  logic [TIMEOUT_W-1:0] timeout_q;
  logic [DEFAULT_W-1:0] dflt_q [CHANNELS];

  logic [TIME_BITS-1:0] tick_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] pulse_start_q;
  logic [TIME_BITS-1:0] last_end_q;
  logic [TIME_BITS-1:0] width_q;
  logic [1:0]           active_q;
  logic [1:0]           fall_ch_q;
  logic                 awaiting_q;
  logic [CHANNELS-1:0]  prev_q;
  logic [VAL_W-1:0]     value_q [CHANNELS];
  logic                 m_valid_q;
  div_req_t             div_req_q;

  logic                     div_done;
  logic [FRACTION_BITS-1:0] div_quot;

  logic [CHANNELS-1:0]  pins;
  logic                 s_fire;
  logic                 was_hi;
  logic                 is_hi;
  logic                 fall;
  logic                 rise;
  logic [TIME_BITS-1:0] excess;
  logic [PULSE_W-1:0]   span;
  logic                 zero_val;
  logic                 full_val;
  logic [TIME_BITS-1:0] elapsed;
  logic                 lost;
  logic                 out_load;
  logic [VAL_W-1:0]     shown [CHANNELS];
  logic [OUT_W-1:0]     m_data_d;

  assign pins   = s_axis_tdata_i[CHANNELS-1:0];
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    was_hi = prev_q[active_q];
    is_hi  = pins[active_q];
    fall   = awaiting_q && was_hi && !is_hi;
    rise   = !awaiting_q && !was_hi && is_hi;
  end

  // normalization checks on the registered width
  always_comb begin
    excess   = width_q - TIME_BITS'(pulse_min_q);
    span     = pulse_max_q - pulse_min_q;
    zero_val = (pulse_max_q <= pulse_min_q) || (width_q <= TIME_BITS'(pulse_min_q));
    full_val = (excess >= TIME_BITS'(span));
  end

  always_comb begin
    elapsed  = now_q - last_end_q;
    lost     = (CFG_DATA_W'(elapsed) > timeout_q);
    out_load = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready_i);
    for (int i = 0; i < CHANNELS; i++) begin
      if (!lost) begin
        shown[i] = value_q[i];
      end else if (CFG_DATA_W'(dflt_q[i]) > OneWide) begin
        shown[i] = ValueOne;
      end else begin
        shown[i] = VAL_W'(dflt_q[i]);
      end
    end
    m_data_d = OUT_W'({shown[3], shown[2], shown[1], shown[0]});
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_min_q <= PULSE_MIN_RST;
      pulse_max_q <= PULSE_MAX_RST;
      timeout_q   <= TIMEOUT_RST;
      dflt_q[0]   <= THR_DEF_RST;
      dflt_q[1]   <= AXIS_DEF_RST;
      dflt_q[2]   <= AXIS_DEF_RST;
      dflt_q[3]   <= AXIS_DEF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PULSE_MIN:   pulse_min_q <= cfg_data_i[PULSE_W-1:0];
        REG_PULSE_MAX:   pulse_max_q <= cfg_data_i[PULSE_W-1:0];
        REG_TIMEOUT:     timeout_q   <= cfg_data_i[TIMEOUT_W-1:0];
        REG_THR_DEFAULT: dflt_q[0]   <= cfg_data_i[DEFAULT_W-1:0];
        REG_YAW_DEFAULT: dflt_q[1]   <= cfg_data_i[DEFAULT_W-1:0];
        REG_PIT_DEFAULT: dflt_q[2]   <= cfg_data_i[DEFAULT_W-1:0];
        REG_ROL_DEFAULT: dflt_q[3]   <= cfg_data_i[DEFAULT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer with edge tracking and channel values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      tick_q        <= '0;
      now_q         <= '0;
      pulse_start_q <= '0;
      last_end_q    <= '0;
      width_q       <= '0;
      active_q      <= '0;
      fall_ch_q     <= '0;
      awaiting_q    <= 1'b0;
      prev_q        <= '0;
      m_valid_q     <= 1'b0;
      div_req_q     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        value_q[i] <= '0;
      end
    end else begin
      div_req_q.start <= 1'b0;
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            now_q  <= tick_q;
            tick_q <= tick_q + 1'b1;
            prev_q <= pins;
            if (fall) begin
              width_q    <= tick_q - pulse_start_q;
              last_end_q <= tick_q;
              fall_ch_q  <= active_q;
              active_q   <= active_q + 1'b1;
              awaiting_q <= 1'b0;
              state_q    <= ST_NORM;
            end else begin
              if (rise) begin
                pulse_start_q <= tick_q;
                awaiting_q    <= 1'b1;
              end
              state_q <= ST_FIN;
            end
          end
        end
        ST_NORM: begin
          if (zero_val) begin
            value_q[fall_ch_q] <= '0;
            state_q            <= ST_FIN;
          end else if (full_val) begin
            value_q[fall_ch_q] <= ValueOne;
            state_q            <= ST_FIN;
          end else begin
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= excess[PULSE_W-1:0];
            div_req_q.divisor  <= span;
            state_q            <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            value_q[fall_ch_q] <= {1'b0, div_quot};
            state_q            <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_axis_tdata_o <= m_data_d;
      m_axis_tuser_o <= lost;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;

  rcpd_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // the divider only finishes while the sequencer waits for it
  a_div_done_in_div : assert property (
    @(posedge clk_i) disable iff (!rst_ni) div_done |-> state_q == ST_DIV
  ) else $error("divider finished outside the divide step");

  // an accepted tick keeps the input closed in the next cycle
  a_busy_after_accept : assert property (
    @(posedge clk_i) disable iff (!rst_ni) s_fire |=> !s_axis_tready_o
  ) else $error("input accepted again before the tick was finished");

  // a shown throttle value never exceeds full scale
  a_value_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> m_axis_tdata_o[VAL_W-1:0] <= ValueOne
  ) else $error("throttle value above full scale");

  // a divide is only started from the normalization step
  a_div_start : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    div_req_q.start |-> $past(state_q) == ST_NORM
  ) else $error("divider started outside normalization");

endmodule
